// ===== design/bpq_pkg.sv =====
package bpq_pkg;

  // Default sizes of the queue.
  localparam int NUM_LEVELS_DEF = 16;
  localparam int NUM_NODES_DEF  = 64;

  // Request codes; codes 5 to 7 are rejected as misuse.
  typedef enum logic [2:0] {
    REQ_APPEND = 3'd0,
    REQ_INSERT = 3'd1,
    REQ_REMOVE = 3'd2,
    REQ_PEEK   = 3'd3,
    REQ_CLEAR  = 3'd4
  } req_t;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_MISUSE = 2'd2
  } status_t;

endpackage

// ===== design/bpq_ram.sv =====
module bpq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/bitmap_priority_list_queue.sv =====
// Channel   | Direction | Handshake            | Word
// ----------+-----------+----------------------+-------------------------------------------
// request   | in        | in_valid / in_stall  | in_req_type, in_node_id, in_level
// result    | out       | out_valid / out_stall| out_status, out_head_node,
//           |           |                      | out_total_queued, out_high_water
//
// Each request is handled as a read and then a write-back: the edge that accepts it reads the link and
// level memories at the node handle, and the write-back pass in S_EXEC writes the neighbour links back
// and loads the result; it is the single read-then-write pass over the node memories.
// Reset is synchronous and clears every list, count and the high-water mark at once; no sweep.
// A stalled result holds the write-back until it can be loaded; a new request may still be
// accepted while a finished result waits on the output.
module bitmap_priority_list_queue #(
  parameter int NUM_LEVELS = bpq_pkg::NUM_LEVELS_DEF,
  parameter int NUM_NODES  = bpq_pkg::NUM_NODES_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [2:0]                       in_req_type,
  input  logic [$clog2(NUM_NODES)-1:0]     in_node_id,
  input  logic [$clog2(NUM_LEVELS)-1:0]    in_level,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [1:0]                       out_status,
  output logic [$clog2(NUM_NODES)-1:0]     out_head_node,
  output logic [$clog2(NUM_NODES+1)-1:0]   out_total_queued,
  output logic [$clog2(NUM_NODES+1)-1:0]   out_high_water
);

  // Node handles index the memories; links and counts need one more code, the
  // value NUM_NODES, which stands for "no node".
  localparam int NODE_W = $clog2(NUM_NODES);
  localparam int LVL_W  = $clog2(NUM_LEVELS);
  localparam int LINK_W = $clog2(NUM_NODES + 1);
  localparam int CNT_W  = $clog2(NUM_NODES + 1);

  localparam logic [LINK_W-1:0] NONE     = LINK_W'(NUM_NODES);
  localparam logic [NODE_W:0]   NODE_LIM = (NODE_W + 1)'(NUM_NODES);
  localparam logic [LVL_W:0]    LVL_LIM  = (LVL_W + 1)'(NUM_LEVELS);

  // Two states: waiting for a request, and the write-back pass of the
  // accepted one.
  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t state_r, state_nxt;

  // Captured request word.
  bpq_pkg::req_t     req_r;
  logic [NODE_W-1:0] node_r;
  logic [LVL_W-1:0]  lvl_r;

  // Per-level list ends and counts, the bitmap and the totals. These are small
  // and reset to known values, so they live in flip-flops.
  logic [LINK_W-1:0]     head_r [NUM_LEVELS];
  logic [LINK_W-1:0]     head_nxt [NUM_LEVELS];
  logic [LINK_W-1:0]     tail_r [NUM_LEVELS];
  logic [LINK_W-1:0]     tail_nxt [NUM_LEVELS];
  logic [CNT_W-1:0]      cnt_r [NUM_LEVELS];
  logic [CNT_W-1:0]      cnt_nxt [NUM_LEVELS];
  logic [NUM_LEVELS-1:0] map_r, map_nxt;
  logic [CNT_W-1:0]      total_r, total_nxt;
  logic [CNT_W-1:0]      peak_r, peak_nxt;
  logic [NUM_NODES-1:0]  queued_r, queued_nxt;

  // Result register.
  logic                  out_valid_r;
  logic [1:0]            out_status_r;
  logic [NODE_W-1:0]     out_head_r;
  logic [CNT_W-1:0]      out_total_r;
  logic [CNT_W-1:0]      out_peak_r;

  // Node memory ports.
  logic                  in_accept;
  logic                  done;
  logic                  next_we, prev_we, lvl_we;
  logic [NODE_W-1:0]     next_waddr, prev_waddr;
  logic [LINK_W-1:0]     next_wdata, prev_wdata;
  logic [LINK_W-1:0]     next_rd, prev_rd;
  logic [LVL_W-1:0]      lvl_rd;

  // Write-back working values.
  bpq_pkg::status_t      status;
  logic [NODE_W-1:0]     head_node;
  logic [LVL_W-1:0]      first_lvl;
  logic                  found;
  logic                  ok_args;
  logic [LINK_W-1:0]     n_link;
  logic [LINK_W-1:0]     cur_head, cur_tail;
  logic [LINK_W-1:0]     p_link, x_link;
  logic [CNT_W-1:0]      cnt_dec;
  logic [CNT_W-1:0]      total_inc;

  assign in_accept = in_valid && !in_stall;
  assign in_stall  = (state_r != S_IDLE);

  // The write-back waits only while an earlier result still sits unread.
  assign done = (state_r == S_EXEC) && (!out_valid_r || !out_stall);

  // Link memories are read at the node handle on the accepting edge. Entries
  // of nodes that are not queued are never trusted, so no clearing is needed.
  bpq_ram #(.WIDTH(LINK_W), .DEPTH(NUM_NODES)) u_next_ram (
    .clk   (clk),
    .we    (next_we),
    .waddr (next_waddr),
    .wdata (next_wdata),
    .re    (in_accept),
    .raddr (in_node_id),
    .rdata (next_rd)
  );

  bpq_ram #(.WIDTH(LINK_W), .DEPTH(NUM_NODES)) u_prev_ram (
    .clk   (clk),
    .we    (prev_we),
    .waddr (prev_waddr),
    .wdata (prev_wdata),
    .re    (in_accept),
    .raddr (in_node_id),
    .rdata (prev_rd)
  );

  bpq_ram #(.WIDTH(LVL_W), .DEPTH(NUM_NODES)) u_level_ram (
    .clk   (clk),
    .we    (lvl_we),
    .waddr (node_r),
    .wdata (lvl_r),
    .re    (in_accept),
    .raddr (in_node_id),
    .rdata (lvl_rd)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (done) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // The request itself. The end markers of a list are recognised from the
  // level's head and tail, so a node's own links never need to be reset to
  // "no node" and each link memory takes at most one write per request.
  always_comb begin
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    cnt_nxt    = cnt_r;
    map_nxt    = map_r;
    total_nxt  = total_r;
    peak_nxt   = peak_r;
    queued_nxt = queued_r;
    next_we    = 1'b0;
    next_waddr = node_r;
    next_wdata = NONE;
    prev_we    = 1'b0;
    prev_waddr = node_r;
    prev_wdata = NONE;
    lvl_we     = 1'b0;
    status     = bpq_pkg::ST_OK;
    head_node  = '0;

    // Lowest-numbered non-empty level.
    first_lvl = '0;
    found     = 1'b0;
    for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
      if (map_r[i]) begin
        first_lvl = LVL_W'(i);
        found     = 1'b1;
      end
    end

    ok_args   = ({1'b0, node_r} < NODE_LIM) && ({1'b0, lvl_r} < LVL_LIM);
    n_link    = LINK_W'(node_r);
    cur_head  = head_r[lvl_r];
    cur_tail  = tail_r[lvl_r];
    p_link    = (cur_head == n_link) ? NONE : prev_rd;
    x_link    = (cur_tail == n_link) ? NONE : next_rd;
    cnt_dec   = (cnt_r[lvl_r] != '0) ? cnt_r[lvl_r] - CNT_W'(1) : '0;
    total_inc = total_r + CNT_W'(1);

    case (req_r)
      bpq_pkg::REQ_APPEND, bpq_pkg::REQ_INSERT: begin
        if (!ok_args || queued_r[node_r]) begin
          status = bpq_pkg::ST_MISUSE;
        end else begin
          if (req_r == bpq_pkg::REQ_APPEND) begin
            prev_we    = 1'b1;
            prev_waddr = node_r;
            prev_wdata = cur_tail;
            if (cur_tail != NONE) begin
              next_we    = 1'b1;
              next_waddr = cur_tail[NODE_W-1:0];
              next_wdata = n_link;
            end else begin
              head_nxt[lvl_r] = n_link;
            end
            tail_nxt[lvl_r] = n_link;
          end else begin
            next_we    = 1'b1;
            next_waddr = node_r;
            next_wdata = cur_head;
            if (cur_head != NONE) begin
              prev_we    = 1'b1;
              prev_waddr = cur_head[NODE_W-1:0];
              prev_wdata = n_link;
            end else begin
              tail_nxt[lvl_r] = n_link;
            end
            head_nxt[lvl_r] = n_link;
          end
          lvl_we             = 1'b1;
          queued_nxt[node_r] = 1'b1;
          cnt_nxt[lvl_r]     = cnt_r[lvl_r] + CNT_W'(1);
          map_nxt[lvl_r]     = 1'b1;
          total_nxt          = total_inc;
          if (total_inc > peak_r) begin
            peak_nxt = total_inc;
          end
        end
      end
      bpq_pkg::REQ_REMOVE: begin
        if (!ok_args || !queued_r[node_r] || (lvl_rd != lvl_r)) begin
          status = bpq_pkg::ST_MISUSE;
        end else begin
          if (p_link != NONE) begin
            next_we    = 1'b1;
            next_waddr = p_link[NODE_W-1:0];
            next_wdata = x_link;
          end else begin
            head_nxt[lvl_r] = x_link;
          end
          if (x_link != NONE) begin
            prev_we    = 1'b1;
            prev_waddr = x_link[NODE_W-1:0];
            prev_wdata = p_link;
          end else begin
            tail_nxt[lvl_r] = p_link;
          end
          queued_nxt[node_r] = 1'b0;
          cnt_nxt[lvl_r]     = cnt_dec;
          if (cnt_dec == '0) begin
            map_nxt[lvl_r] = 1'b0;
          end
          if (total_r != '0) begin
            total_nxt = total_r - CNT_W'(1);
          end
        end
      end
      bpq_pkg::REQ_PEEK: begin
        status = bpq_pkg::ST_EMPTY;
        if ((total_r != '0) && found && (head_r[first_lvl] != NONE)) begin
          head_node = head_r[first_lvl][NODE_W-1:0];
          status    = bpq_pkg::ST_OK;
        end
      end
      bpq_pkg::REQ_CLEAR: begin
        for (int i = 0; i < NUM_LEVELS; i++) begin
          head_nxt[i] = NONE;
          tail_nxt[i] = NONE;
          cnt_nxt[i]  = '0;
        end
        queued_nxt = '0;
        map_nxt    = '0;
        total_nxt  = '0;
        peak_nxt   = '0;
      end
      default: begin
        status = bpq_pkg::ST_MISUSE;
      end
    endcase

    // Nothing reaches the memories or the state unless the pass completes.
    if (!done) begin
      next_we = 1'b0;
      prev_we = 1'b0;
      lvl_we  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      map_r       <= '0;
      total_r     <= '0;
      peak_r      <= '0;
      queued_r    <= '0;
      for (int i = 0; i < NUM_LEVELS; i++) begin
        head_r[i] <= NONE;
        tail_r[i] <= NONE;
        cnt_r[i]  <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (done) begin
        out_valid_r <= 1'b1;
        map_r       <= map_nxt;
        total_r     <= total_nxt;
        peak_r      <= peak_nxt;
        queued_r    <= queued_nxt;
        head_r      <= head_nxt;
        tail_r      <= tail_nxt;
        cnt_r       <= cnt_nxt;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Request and result words carry no reset.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      req_r  <= bpq_pkg::req_t'(in_req_type);
      node_r <= in_node_id;
      lvl_r  <= in_level;
    end
    if (done) begin
      out_status_r <= status;
      out_head_r   <= head_node;
      out_total_r  <= total_nxt;
      out_peak_r   <= peak_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_head_node    = out_head_r;
  assign out_total_queued = out_total_r;
  assign out_high_water   = out_peak_r;

  a_accept_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> (state_r == S_EXEC))
    else $error("accepted request did not enter write-back");

  a_result_from_exec: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_EXEC))
    else $error("result appeared without a write-back pass");

  a_peak_covers_total: assert property (@(posedge clk) disable iff (!rst_n)
    (peak_r >= total_r) && ({1'b0, total_r} <= {1'b0, NONE}))
    else $error("total out of range or above high-water mark");

  a_empty_map: assert property (@(posedge clk) disable iff (!rst_n)
    (total_r == '0) |-> (map_r == '0))
    else $error("level bitmap set while nothing is queued");

endmodule
